FILE: src/avr_pkg.sv
// Shared constants, types and the arctangent table for the axis vector rotator.
package avr_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// CORDIC datapath: 32-bit phase (full turn = 2^32), 30 fraction bits on sin/cos
	localparam int PHASE_W   = 32;
	localparam int CORD_W    = 32;
	localparam int FRAC_BITS = 30;

	localparam logic signed [CORD_W-1:0] GAIN_Q30 = 32'sd652032874;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;

	// axis codes on func
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] func;
	} avr_ctl_t;

	localparam logic [PHASE_W-1:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	function automatic logic [PHASE_W-1:0] atan_turn(input logic [4:0] idx);
		return ATAN_TURNS[idx];
	endfunction

endpackage

FILE: src/avr_cell.sv
// One CORDIC micro-rotation cell of the rotator chain.
module avr_cell #(
	parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF,
	parameter int STAGE       = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  avr_pkg::avr_ctl_t                     ctl,
	input  logic signed [COORD_WIDTH-1:0]         vx,
	input  logic signed [COORD_WIDTH-1:0]         vy,
	input  logic signed [COORD_WIDTH-1:0]         vz,
	input  logic signed [avr_pkg::CORD_W-1:0]     cx,
	input  logic signed [avr_pkg::CORD_W-1:0]     cy,
	input  logic [avr_pkg::PHASE_W-1:0]           ph,
	output avr_pkg::avr_ctl_t                     ctl_q,
	output logic signed [COORD_WIDTH-1:0]         vx_q,
	output logic signed [COORD_WIDTH-1:0]         vy_q,
	output logic signed [COORD_WIDTH-1:0]         vz_q,
	output logic signed [avr_pkg::CORD_W-1:0]     cx_q,
	output logic signed [avr_pkg::CORD_W-1:0]     cy_q,
	output logic [avr_pkg::PHASE_W-1:0]           ph_q
);

	localparam logic [avr_pkg::PHASE_W-1:0] ATAN = avr_pkg::atan_turn(5'(STAGE));

	logic signed [avr_pkg::CORD_W-1:0] dx;
	logic signed [avr_pkg::CORD_W-1:0] dy;
	logic signed [avr_pkg::CORD_W-1:0] cx_nx;
	logic signed [avr_pkg::CORD_W-1:0] cy_nx;
	logic [avr_pkg::PHASE_W-1:0]       ph_nx;

	assign dx = cy >>> STAGE;
	assign dy = cx >>> STAGE;

	// rotate towards zero residual phase
	always_comb begin
		if (ph[avr_pkg::PHASE_W-1]) begin
			cx_nx = cx + dx;
			cy_nx = cy - dy;
			ph_nx = ph + ATAN;
		end else begin
			cx_nx = cx - dx;
			cy_nx = cy + dy;
			ph_nx = ph - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q <= vx;
			vy_q <= vy;
			vz_q <= vz;
			cx_q <= cx_nx;
			cy_q <= cy_nx;
			ph_q <= ph_nx;
		end
	end

endmodule

FILE: src/avr_mix.sv
// Multiply the selected coordinate pair by cos/sin, round and saturate.
module avr_mix #(
	parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  avr_pkg::avr_ctl_t                     ctl,
	input  logic signed [COORD_WIDTH-1:0]         vx,
	input  logic signed [COORD_WIDTH-1:0]         vy,
	input  logic signed [COORD_WIDTH-1:0]         vz,
	input  logic signed [avr_pkg::CORD_W-1:0]     cosv,
	input  logic signed [avr_pkg::CORD_W-1:0]     sinv,
	output avr_pkg::avr_ctl_t                     ctl_s3,
	output logic signed [COORD_WIDTH-1:0]         rx_s3,
	output logic signed [COORD_WIDTH-1:0]         ry_s3,
	output logic signed [COORD_WIDTH-1:0]         rz_s3,
	output logic                                  sat_s3
);

	localparam int PW = COORD_WIDTH + avr_pkg::CORD_W;
	localparam int SW = PW + 1;
	localparam int RW = SW - avr_pkg::FRAC_BITS;
	localparam logic signed [SW-1:0] RND = SW'(1) << (avr_pkg::FRAC_BITS - 1);
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// stage 1: pick the pair, four products
	logic signed [COORD_WIDTH-1:0] a;
	logic signed [COORD_WIDTH-1:0] b;
	avr_pkg::avr_ctl_t             ctl_s1;
	logic signed [COORD_WIDTH-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [PW-1:0]          p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;

	always_comb begin
		unique case (ctl.func)
			avr_pkg::AXIS_X: begin
				a = vy;
				b = vz;
			end
			avr_pkg::AXIS_Y: begin
				a = vx;
				b = vz;
			end
			avr_pkg::AXIS_Z: begin
				a = vx;
				b = vy;
			end
			avr_pkg::AXIS_NONE: begin
				a = vx;
				b = vy;
			end
		endcase
	end

	// stage 2: sum, round half up, drop fraction
	logic signed [SW-1:0]          sum1, sum2;
	logic signed [SW-1:0]          sh1, sh2;
	avr_pkg::avr_ctl_t             ctl_s2;
	logic signed [COORD_WIDTH-1:0] vx_s2, vy_s2, vz_s2;
	logic signed [RW-1:0]          r1_s2, r2_s2;

	assign sum1 = $signed({p_ac_s1[PW-1], p_ac_s1}) - $signed({p_bs_s1[PW-1], p_bs_s1}) + RND;
	assign sum2 = $signed({p_as_s1[PW-1], p_as_s1}) + $signed({p_bc_s1[PW-1], p_bc_s1}) + RND;
	assign sh1  = sum1 >>> avr_pkg::FRAC_BITS;
	assign sh2  = sum2 >>> avr_pkg::FRAC_BITS;

	// stage 3: clip to the coordinate range, write back by axis
	logic                          fit1, fit2;
	logic signed [COORD_WIDTH-1:0] c1, c2;
	logic signed [COORD_WIDTH-1:0] rx_nx, ry_nx, rz_nx;
	logic                          sat_nx;

	always_comb begin
		fit1 = (&r1_s2[RW-1:COORD_WIDTH-1]) | ~(|r1_s2[RW-1:COORD_WIDTH-1]);
		fit2 = (&r2_s2[RW-1:COORD_WIDTH-1]) | ~(|r2_s2[RW-1:COORD_WIDTH-1]);
		c1   = fit1 ? r1_s2[COORD_WIDTH-1:0] : (r1_s2[RW-1] ? CMIN : CMAX);
		c2   = fit2 ? r2_s2[COORD_WIDTH-1:0] : (r2_s2[RW-1] ? CMIN : CMAX);
		rx_nx  = vx_s2;
		ry_nx  = vy_s2;
		rz_nx  = vz_s2;
		sat_nx = ~(fit1 & fit2);
		unique case (ctl_s2.func)
			avr_pkg::AXIS_X: begin
				ry_nx = c1;
				rz_nx = c2;
			end
			avr_pkg::AXIS_Y: begin
				rx_nx = c1;
				rz_nx = c2;
			end
			avr_pkg::AXIS_Z: begin
				rx_nx = c1;
				ry_nx = c2;
			end
			avr_pkg::AXIS_NONE: begin
				sat_nx = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1   <= vx;
			vy_s1   <= vy;
			vz_s1   <= vz;
			p_ac_s1 <= a * cosv;
			p_bs_s1 <= b * sinv;
			p_as_s1 <= a * sinv;
			p_bc_s1 <= b * cosv;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			vz_s2   <= vz_s1;
			r1_s2   <= sh1[RW-1:0];
			r2_s2   <= sh2[RW-1:0];
			rx_s3   <= rx_nx;
			ry_s3   <= ry_nx;
			rz_s3   <= rz_nx;
			sat_s3  <= sat_nx;
		end
	end

endmodule

FILE: src/axis_vector_rotator.sv
// Top level: 3D vector rotation about one axis with a pipelined CORDIC chain.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   vector   | vec_valid, vec_stall | func, vec_x, vec_y, vec_z, angle
//   result   | rot_valid, rot_stall | out_x, out_y, out_z, saturated
//
// One item per cycle enters while vec_stall is low and passes the phase fold,
// one cell per CORDIC stage, multiply, round, clip and the output register.
// A two-entry output (register plus skid) lets the chain keep moving while a
// result waits; vec_stall is registered and rises only once the skid is full.
// Reset empties the chain and the output; no clearing pass is needed.
module axis_vector_rotator #(
	parameter int COORD_WIDTH   = avr_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = avr_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = avr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vec_valid,
	output logic                          vec_stall,
	input  logic [1:0]                    func,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic signed [COORD_WIDTH-1:0] vec_z,
	input  logic [ANGLE_WIDTH-1:0]        angle,
	output logic                          rot_valid,
	input  logic                          rot_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          saturated
);

	localparam int PHW = avr_pkg::PHASE_W;
	localparam int CRW = avr_pkg::CORD_W;

	logic adv;
	logic skid_full_q;

	assign adv       = ~skid_full_q;
	assign vec_stall = skid_full_q;

	// phase fold: bring the angle into [-quarter, +quarter), start at +-K
	logic [PHW-1:0] ph_raw;
	logic           fold;

	assign ph_raw = PHW'(angle) << (PHW - ANGLE_WIDTH);
	assign fold   = ph_raw[PHW-1] ^ ph_raw[PHW-2];

	avr_pkg::avr_ctl_t             ctl_c [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] vx_c  [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] vy_c  [0:CORDIC_STAGES];
	logic signed [COORD_WIDTH-1:0] vz_c  [0:CORDIC_STAGES];
	logic signed [CRW-1:0]         cx_c  [0:CORDIC_STAGES];
	logic signed [CRW-1:0]         cy_c  [0:CORDIC_STAGES];
	logic [PHW-1:0]                ph_c  [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (adv) begin
			ctl_c[0].valid <= vec_valid;
			ctl_c[0].func  <= func;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_c[0] <= vec_x;
			vy_c[0] <= vec_y;
			vz_c[0] <= vec_z;
			cx_c[0] <= fold ? -avr_pkg::GAIN_Q30 : avr_pkg::GAIN_Q30;
			cy_c[0] <= '0;
			ph_c[0] <= fold ? (ph_raw ^ avr_pkg::HALF_TURN) : ph_raw;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		avr_cell #(
			.COORD_WIDTH(COORD_WIDTH),
			.STAGE      (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctl   (ctl_c[i]),
			.vx    (vx_c[i]),
			.vy    (vy_c[i]),
			.vz    (vz_c[i]),
			.cx    (cx_c[i]),
			.cy    (cy_c[i]),
			.ph    (ph_c[i]),
			.ctl_q (ctl_c[i+1]),
			.vx_q  (vx_c[i+1]),
			.vy_q  (vy_c[i+1]),
			.vz_q  (vz_c[i+1]),
			.cx_q  (cx_c[i+1]),
			.cy_q  (cy_c[i+1]),
			.ph_q  (ph_c[i+1])
		);
	end

	avr_pkg::avr_ctl_t             mix_ctl;
	logic signed [COORD_WIDTH-1:0] mix_x, mix_y, mix_z;
	logic                          mix_sat;

	avr_mix #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mix (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.ctl   (ctl_c[CORDIC_STAGES]),
		.vx    (vx_c[CORDIC_STAGES]),
		.vy    (vy_c[CORDIC_STAGES]),
		.vz    (vz_c[CORDIC_STAGES]),
		.cosv  (cx_c[CORDIC_STAGES]),
		.sinv  (cy_c[CORDIC_STAGES]),
		.ctl_s3(mix_ctl),
		.rx_s3 (mix_x),
		.ry_s3 (mix_y),
		.rz_s3 (mix_z),
		.sat_s3(mix_sat)
	);

	// output register plus skid
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
	logic                          out_sat_q;
	logic signed [COORD_WIDTH-1:0] skid_x_q, skid_y_q, skid_z_q;
	logic                          skid_sat_q;
	logic                          take;
	logic                          produced;

	assign take     = out_valid_q & ~rot_stall;
	assign produced = adv & mix_ctl.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			priority if (skid_full_q) begin
				if (take) begin
					skid_full_q <= 1'b0;
				end
			end else if (produced) begin
				if (out_valid_q && !take) begin
					skid_full_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_x_q   <= skid_x_q;
				out_y_q   <= skid_y_q;
				out_z_q   <= skid_z_q;
				out_sat_q <= skid_sat_q;
			end
		end else if (produced) begin
			if (out_valid_q && !take) begin
				skid_x_q   <= mix_x;
				skid_y_q   <= mix_y;
				skid_z_q   <= mix_z;
				skid_sat_q <= mix_sat;
			end else begin
				out_x_q   <= mix_x;
				out_y_q   <= mix_y;
				out_z_q   <= mix_z;
				out_sat_q <= mix_sat;
			end
		end
	end

	assign rot_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign saturated = out_sat_q;

`ifndef ASSERT_OFF
	a_skid_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds an item with the output register empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && rot_stall))
		else $error("skid filled while the output was free");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && rot_stall |=> skid_full_q)
		else $error("skid item dropped under stall");
`endif

endmodule
